// ===== design/ksa_pkg.sv =====
// ----------------------------------------------------------------------------
// ksa_pkg
// types, constants and helpers shared by the kmer signal accumulator
// ----------------------------------------------------------------------------
package ksa_pkg;

   localparam int KmerLen    = 10;
   localparam int Up         = 7;
   localparam int IdxW       = 2 * KmerLen;
   localparam int TabAw      = 20;
   localparam int TabDepth   = 1 << TabAw;
   localparam int SumW       = 33;
   localparam int CntW       = 17;
   localparam int MeanW      = 16;
   localparam int RunW       = 5;
   localparam int DelayDepth = (Up < KmerLen - 1) ? (KmerLen - 1 - Up) : 1;
   localparam int EntryW     = SumW + CntW;
   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   localparam logic [CntW-1:0] CountLimitReset = 17'd100000;

   localparam logic [2:0] StatNone    = 3'd0;
   localparam logic [2:0] StatNoSig   = 3'd1;
   localparam logic [2:0] StatAccum   = 3'd2;
   localparam logic [2:0] StatDropped = 3'd3;
   localparam logic [2:0] StatRead    = 3'd4;

   localparam logic CmdPush = 1'b0;
   localparam logic CmdRead = 1'b1;

   typedef struct packed {
      logic        command;
      logic [7:0]  base_char;
      logic        signal_valid;
      logic [15:0] signal_value;
      logic [19:0] query_index;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [19:0]     entry_index;
      logic [SumW-1:0] entry_sum;
      logic [CntW-1:0] entry_count;
      logic [MeanW-1:0] entry_mean;
   } rsp_type;

   // classified work from front to back
   typedef struct packed {
      logic        is_read;
      logic        full;
      logic        have_sig;
      logic [15:0] value;
      logic [19:0] index;
   } job_type;

   function automatic logic [2:0] base_code(input logic [7:0] c);
      case (c)
         8'd65, 8'd97:  base_code = 3'b100;
         8'd84, 8'd116: base_code = 3'b101;
         8'd67, 8'd99:  base_code = 3'b110;
         8'd71, 8'd103: base_code = 3'b111;
         default:       base_code = 3'b000;
      endcase
   endfunction

endpackage

// ===== design/kmer_signal_accumulator.sv =====
// ----------------------------------------------------------------------------
// kmer_signal_accumulator
// per-kmer signal sum and count tables fed by a streamed base sequence
//
// channel  | direction | payload
// req_     | in        | req_type: command, base, signal, query index
// rsp_     | out       | rsp_type: status, index, sum, count, mean
// csr_     | in        | count limit, 17 bits
//
// push: the back end reads, modify-writes and hands off each request;
// when the window is not full it hands off without a table read
// read: the reply waits on the one-bit-per-cycle mean divider
// after reset the back end clears the 2^20 entry table;
// requests queue in a 4 entry fifo and then wait
// a stalled rsp_ holds the back end; the front keeps filling the queue
// ----------------------------------------------------------------------------
module kmer_signal_accumulator import ksa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CntW-1:0] csr_data
);
   logic [CntW-1:0] limit_ff;
   logic            fq_valid, fq_ready, qb_valid, qb_ready;
   job_type         fq_data, qb_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CountLimitReset;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   ksa_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .job_valid(fq_valid), .job_ready(fq_ready),
      .job_data(fq_data));

   ksa_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(fq_valid), .in_ready(fq_ready),
      .in_data(fq_data), .out_valid(qb_valid), .out_ready(qb_ready),
      .out_data(qb_data));

   ksa_back u_back (
      .clock(clock), .reset(reset), .count_limit(limit_ff),
      .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule

// ===== design/ksa_ram.sv =====
// ----------------------------------------------------------------------------
// ksa_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ksa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/ksa_front.sv =====
// ----------------------------------------------------------------------------
// ksa_front
// window tracking, signal delay line and request classification
// ----------------------------------------------------------------------------
module ksa_front import ksa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);
   logic [IdxW-1:0] window_ff, window_in;
   logic [RunW-1:0] run_ff, run_in;
   logic [15:0]     dval_ff [DelayDepth];
   logic            dvld_ff [DelayDepth];
   logic [2:0]      code;
   logic            take;
   job_type         job;

   assign req_ready = job_ready;
   assign take      = req_valid && req_ready;
   assign code      = base_code(req_data.base_char);

   always_comb begin
      window_in = window_ff;
      run_in    = run_ff;
      if (!code[2]) begin
         window_in = '0;
         run_in    = '0;
      end else begin
         window_in = {window_ff[IdxW-3:0], code[1:0]};
         if (run_ff < RunW'(KmerLen)) begin
            run_in = run_ff + 1'b1;
         end
      end
   end

   always_comb begin
      job          = '0;
      job.is_read  = req_data.command == CmdRead;
      if (job.is_read) begin
         job.index = req_data.query_index;
      end else if (code[2] && run_in >= RunW'(KmerLen)) begin
         job.full  = 1'b1;
         job.index = 20'(window_in);
         if (Up < KmerLen) begin
            if (KmerLen - 1 - Up == 0) begin
               job.have_sig = req_data.signal_valid;
               job.value    = req_data.signal_value;
            end else begin
               job.have_sig = dvld_ff[DelayDepth-1];
               job.value    = dval_ff[DelayDepth-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         run_ff    <= '0;
         for (int i = 0; i < DelayDepth; i++) begin
            dvld_ff[i] <= 1'b0;
            dval_ff[i] <= '0;
         end
      end else if (take && req_data.command == CmdPush) begin
         window_ff  <= window_in;
         run_ff     <= run_in;
         dvld_ff[0] <= req_data.signal_valid;
         dval_ff[0] <= req_data.signal_value;
         for (int i = 1; i < DelayDepth; i++) begin
            dvld_ff[i] <= dvld_ff[i-1];
            dval_ff[i] <= dval_ff[i-1];
         end
      end
   end

   assign job_valid = req_valid;
   assign job_data  = job;
endmodule

// ===== design/ksa_queue.sv =====
// ----------------------------------------------------------------------------
// ksa_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
module ksa_queue import ksa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_data
);
   job_type          slot_ff [QueueDepth];
   logic [QueueAw-1:0] wptr_ff, rptr_ff;
   logic [QueueAw:0]   fill_ff;
   logic push, pop;

   assign in_ready  = fill_ff != (QueueAw+1)'(QueueDepth);
   assign out_valid = fill_ff != '0;
   assign out_data  = slot_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop) rptr_ff <= rptr_ff + 1'b1;
         fill_ff <= fill_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (QueueAw+1)'(QueueDepth))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count lost a push");
endmodule

// ===== design/ksa_divider.sv =====
// ----------------------------------------------------------------------------
// ksa_divider
// radix-2 restoring divider for the rounded mean
// ----------------------------------------------------------------------------
module ksa_divider import ksa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SumW-1:0]  sum,
   input  logic [CntW-1:0]  count,
   output logic             done,
   output logic [MeanW-1:0] mean
);
   localparam int NumW = SumW + 1;
   logic [NumW-1:0] num_ff, num_in;
   logic [CntW:0]   rem_ff, rem_in;
   logic [CntW-1:0] den_ff;
   logic [5:0]      step_ff, step_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [CntW+1:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[NumW-1]} - {2'b0, den_ff};
      if (start) begin
         num_in  = NumW'(sum) + NumW'(count >> 1);
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[CntW+1]) begin
            rem_in = trial[CntW:0];
            num_in = {num_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CntW-1:0], num_ff[NumW-1]};
            num_in = {num_ff[NumW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == 6'(NumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) den_ff <= count;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign mean = (den_ff == '0) ? '0 :
                 (num_ff[NumW-1:MeanW] != '0) ? '1 : num_ff[MeanW-1:0];
endmodule

// ===== design/ksa_back.sv =====
// ----------------------------------------------------------------------------
// ksa_back
// table clear, read-modify-write update, read replies with mean
// ----------------------------------------------------------------------------
module ksa_back import ksa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [CntW-1:0] count_limit,
   input  logic            job_valid,
   output logic            job_ready,
   input  job_type         job_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data
);
   localparam logic [2:0] StClear = 3'd0;
   localparam logic [2:0] StIdle  = 3'd1;
   localparam logic [2:0] StRead  = 3'd2;
   localparam logic [2:0] StData  = 3'd3;
   localparam logic [2:0] StDiv   = 3'd4;
   localparam logic [2:0] StOut   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [TabAw:0]    clr_ff, clr_in;
   job_type           job_ff, job_in;
   rsp_type           rsp_ff, rsp_in;
   logic              we;
   logic [TabAw-1:0]  addr;
   logic [EntryW-1:0] wdata, rdata;
   logic [SumW-1:0]   rsum;
   logic [CntW-1:0]   rcnt;
   logic              div_start, div_done;
   logic [MeanW-1:0]  mean;

   assign rsum = rdata[EntryW-1:CntW];
   assign rcnt = rdata[CntW-1:0];

   ksa_ram #(.Width(EntryW), .Depth(TabDepth)) u_table (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   ksa_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .sum(rsum),
      .count(rcnt), .done(div_done), .mean(mean));

   assign job_ready = state_ff == StIdle;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      job_in    = job_ff;
      rsp_in    = rsp_ff;
      we        = 1'b0;
      addr      = job_ff.index[TabAw-1:0];
      wdata     = '0;
      div_start = 1'b0;
      case (state_ff)
         StClear: begin
            we     = 1'b1;
            addr   = clr_ff[TabAw-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (TabAw+1)'(TabDepth - 1)) state_in = StIdle;
         end
         StIdle: begin
            if (job_valid) begin
               job_in = job_data;
               rsp_in = '0;
               if (job_data.is_read || (job_data.full && job_data.have_sig)) begin
                  state_in = StRead;
               end else begin
                  rsp_in.status      = job_data.full ? StatNoSig : StatNone;
                  rsp_in.entry_index = job_data.index;
                  state_in = job_data.full ? StRead : StOut;
               end
            end
         end
         StRead: state_in = StData;
         StData: begin
            rsp_in.entry_index = job_ff.index;
            rsp_in.entry_sum   = rsum;
            rsp_in.entry_count = rcnt;
            if (job_ff.is_read) begin
               rsp_in.status = StatRead;
               div_start     = 1'b1;
               state_in      = StDiv;
            end else begin
               if (job_ff.have_sig) begin
                  if (rcnt < count_limit) begin
                     rsp_in.status      = StatAccum;
                     rsp_in.entry_sum   = rsum + SumW'(job_ff.value);
                     rsp_in.entry_count = rcnt + 1'b1;
                     we    = 1'b1;
                     wdata = {rsp_in.entry_sum, rsp_in.entry_count};
                  end else begin
                     rsp_in.status = StatDropped;
                  end
               end else begin
                  rsp_in.status = StatNoSig;
               end
               state_in = StOut;
            end
         end
         StDiv: begin
            if (div_done) begin
               rsp_in.entry_mean = mean;
               state_in          = StOut;
            end
         end
         StOut: if (rsp_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= StClear;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   assign rsp_valid = state_ff == StOut;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StOut && !rsp_ready) |=> state_ff == StOut)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == StatAccum) |-> rsp_data.entry_count != '0)
      else $error("accumulated entry with zero count");
   assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff == StClear || state_ff == StData))
      else $error("table written outside update");
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// streams base sequences, signal values and table reads into the kmer
// signal accumulator under several count limits, with random sender gaps
// and receiver stalls, and checks every response against a predictor that
// keeps its own window, signal delay line and sparse sum and count tables
// ----------------------------------------------------------------------------
module tb_top;
   import ksa_pkg::*;

   localparam int DelaySlots = 16;

   class kmer_scoreboard;
      rsp_type                     expected_q[$];
      longint unsigned             sum_tab[int unsigned];
      int unsigned                 cnt_tab[int unsigned];
      logic [IdxW-1:0]             window;
      int                          run;
      logic [15:0]                 dly_value[DelaySlots];
      bit                          dly_valid[DelaySlots];
      int unsigned                 limit;
      int unsigned                 last_kmer;
      int                          errors;

      function new();
         window    = '0;
         run       = 0;
         limit     = 32'(CountLimitReset);
         last_kmer = 0;
         errors    = 0;
         for (int i = 0; i < DelaySlots; i++) begin
            dly_value[i] = '0;
            dly_valid[i] = 0;
         end
      endfunction

      function int code_of(logic [7:0] c);
         case (c)
            "A", "a": return 0;
            "T", "t": return 1;
            "C", "c": return 2;
            "G", "g": return 3;
            default:  return -1;
         endcase
      endfunction

      function void note_request(req_type r);
         rsp_type         e;
         int unsigned     slot;
         longint unsigned s;
         longint unsigned c;
         longint unsigned m;
         int              code;
         int              back;
         bit              have;
         logic [15:0]     val;
         e = '0;
         if (r.command == CmdRead) begin
            slot = 32'(r.query_index) % TabDepth;
            s = sum_tab.exists(slot) ? sum_tab[slot] : 0;
            c = cnt_tab.exists(slot) ? cnt_tab[slot] : 0;
            m = (c != 0) ? (s + c / 2) / c : 0;
            if (m > 65535) m = 65535;
            e.status      = StatRead;
            e.entry_index = r.query_index;
            e.entry_sum   = SumW'(s);
            e.entry_count = CntW'(c);
            e.entry_mean  = MeanW'(m);
         end else begin
            code = code_of(r.base_char);
            for (int i = DelaySlots - 1; i > 0; i--) begin
               dly_value[i] = dly_value[i-1];
               dly_valid[i] = dly_valid[i-1];
            end
            dly_value[0] = r.signal_value;
            dly_valid[0] = r.signal_valid;
            if (code < 0) begin
               run    = 0;
               window = '0;
            end else begin
               window = {window[IdxW-3:0], 2'(code)};
               if (run < KmerLen) run++;
            end
            if (code >= 0 && run >= KmerLen) begin
               slot = 32'(window) % TabDepth;
               last_kmer = 32'(window);
               have = 0;
               val  = '0;
               if (Up < KmerLen) begin
                  back = KmerLen - 1 - Up;
                  if (back < DelaySlots && dly_valid[back]) begin
                     have = 1;
                     val  = dly_value[back];
                  end
               end
               s = sum_tab.exists(slot) ? sum_tab[slot] : 0;
               c = cnt_tab.exists(slot) ? cnt_tab[slot] : 0;
               if (!have) begin
                  e.status = StatNoSig;
               end else if (c < limit) begin
                  s = (s + val) & 64'h1_FFFF_FFFF;
                  c = (c + 1) & 64'h1_FFFF;
                  sum_tab[slot] = s;
                  cnt_tab[slot] = 32'(c);
                  e.status = StatAccum;
               end else begin
                  e.status = StatDropped;
               end
               e.entry_index = window;
               e.entry_sum   = SumW'(s);
               e.entry_count = CntW'(c);
            end
         end
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, a);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status exp %0d act %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.entry_index !== e.entry_index) begin
            $display("%0t: entry_index exp %h act %h", $time, e.entry_index,
                     a.entry_index);
            errors++;
         end
         if (a.entry_sum !== e.entry_sum) begin
            $display("%0t: entry_sum exp %h act %h", $time, e.entry_sum, a.entry_sum);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $display("%0t: entry_count exp %0d act %0d", $time, e.entry_count,
                     a.entry_count);
            errors++;
         end
         if (a.entry_mean !== e.entry_mean) begin
            $display("%0t: entry_mean exp %h act %h", $time, e.entry_mean, a.entry_mean);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [CntW-1:0] csr_data;

   kmer_scoreboard sb;
   int             burst_left;
   int             stall_mode;

   kmer_signal_accumulator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // response checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // receiver stall pattern
   initial begin
      rsp_ready  = 0;
      stall_mode = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready = 1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            default: rsp_ready = ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic send_request(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid = 1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
      req_valid = 0;
      req_data  = '0;
   endtask

   task automatic write_limit(logic [CntW-1:0] v);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      @(negedge clock);
      csr_valid = 1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      sb.limit = 32'(v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic req_type push_of(logic [7:0] c, logic sv, logic [15:0] v);
      req_type r;
      r = '0;
      r.command      = CmdPush;
      r.base_char    = c;
      r.signal_valid = sv;
      r.signal_value = v;
      r.query_index  = 20'($urandom);
      return r;
   endfunction

   function automatic req_type read_of(logic [19:0] q);
      req_type r;
      r = '0;
      r.signal_valid = 1'($urandom);
      r.signal_value = 16'($urandom);
      r.base_char    = 8'($urandom);
      r.command      = CmdRead;
      r.query_index  = q;
      return r;
   endfunction

   function automatic logic [7:0] rand_base();
      byte unsigned set[8] = '{"A", "a", "T", "t", "C", "c", "G", "g"};
      return set[$urandom_range(0, 7)];
   endfunction

   task automatic run_random(int n);
      byte unsigned pat[$];
      int           plen;
      int           total;
      int           sent;
      int           k;
      sent = 0;
      while (sent < n) begin
         k = $urandom_range(0, 99);
         if (k < 10) begin
            send_request(read_of(($urandom_range(0, 2) == 0) ? 20'($urandom)
                                                              : 20'(sb.last_kmer)));
            sent++;
         end else if (k < 18) begin
            send_request(push_of(8'($urandom), 1'($urandom), 16'($urandom)));
            sent++;
         end else begin
            pat.delete();
            plen  = $urandom_range(1, 12);
            total = $urandom_range(10, 60);
            repeat (plen) pat.push_back(rand_base());
            for (int i = 0; i < total; i++) begin
               send_request(push_of(($urandom_range(0, 49) == 0) ? 8'($urandom)
                                                                 : pat[i % plen],
                                    $urandom_range(0, 6) != 0,
                                    ($urandom_range(0, 9) == 0) ? 16'hffff
                                                                : 16'($urandom)));
            end
            sent += total;
         end
      end
   endtask

   initial begin
      byte unsigned seq[10] = '{"A", "c", "G", "t", "a", "C", "g", "T", "A", "A"};
      sb         = new();
      burst_left = 0;
      reset      = 1;
      req_valid  = 0;
      req_data   = '0;
      csr_valid  = 0;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: both cases of each base, breaks, signal extremes, reads
      send_request(read_of(20'h0));
      send_request(read_of(20'hfffff));
      for (int i = 0; i < 10; i++) send_request(push_of(seq[i], 1, 16'hffff));
      send_request(push_of("A", 1, 16'h0000));
      send_request(push_of("A", 0, 16'h1234));
      send_request(push_of("N", 1, 16'hffff));
      send_request(push_of(8'hff, 1, 16'h00ff));
      send_request(push_of(8'h00, 0, 16'h0000));
      for (int i = 0; i < 6; i++) send_request(push_of(seq[i], 1, 16'h0100));
      send_request(read_of(20'(sb.last_kmer)));
      send_request(read_of(20'h12345));

      run_random(320);
      write_limit(17'd1);
      run_random(320);
      write_limit(17'h1ffff);
      run_random(320);
      write_limit(17'd3);
      run_random(320);
      write_limit(17'd0);
      run_random(160);
      write_limit(17'd100000);
      run_random(160);

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
